@@ hdl/level_switch_with_delays_top_assert.svh @@
// assertion macros used by the checker file
`ifndef LEVEL_SWITCH_WITH_DELAYS_TOP_ASSERT_SVH
`define LEVEL_SWITCH_WITH_DELAYS_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LSWD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define LSWD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/lswd_pkg.sv @@
// ----------------------------------------------------------------------------
// lswd_pkg
// Shared constants, types and register codes of the level switch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lswd_pkg;

  // field widths
  localparam int SAMPLE_BITS   = 24;
  localparam int COUNT_BITS    = 24;
  localparam int FRACTION_BITS = 16;
  localparam int PROGRESS_BITS = FRACTION_BITS + 1;

  // stream and config port widths
  localparam int S_TDATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int M_TDATA_BITS   = ((PROGRESS_BITS + 1 + 7) / 8) * 8;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = (SAMPLE_BITS > COUNT_BITS) ? SAMPLE_BITS : COUNT_BITS;

  // divider step counter
  localparam int STEP_BITS = $clog2(FRACTION_BITS);

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_THRESHOLD = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_ON_DELAY        = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_OFF_DELAY       = CFG_INDEX_BITS'(2);

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CALC   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture sample and divider operands
    logic update;  // advance gate state and hold counter
    logic step;    // one divider iteration
    logic finish;  // write result into output register
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic slot_free;  // output register can take a result this cycle
  } dp_status_t;

endpackage

@@ hdl/lswd_ctrl.sv @@
// ----------------------------------------------------------------------------
// lswd_ctrl
// Controller: sequences accept, state update, divide steps and result write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lswd_ctrl import lswd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t               state;
  state_t               state_next;
  logic [STEP_BITS-1:0] step_cnt;
  logic [STEP_BITS-1:0] step_cnt_next;

  // next state and commands
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load      = 1'b1;
          step_cnt_next = '0;
          state_next    = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.step      = 1'b1;
        cmd.update    = (step_cnt == '0);
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == STEP_BITS'(FRACTION_BITS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.slot_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

endmodule

@@ hdl/lswd_dp.sv @@
// ----------------------------------------------------------------------------
// lswd_dp
// Datapath: config registers, gate state, hold counter, restoring divider
// and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lswd_dp import lswd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  ctrl_cmd_t                 cmd,
  output dp_status_t                status,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic [SAMPLE_BITS-1:0]    sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      gate_on,
  output logic [PROGRESS_BITS-1:0]  progress
);

  localparam logic [COUNT_BITS-1:0]    COUNT_MAX = '1;
  localparam logic [PROGRESS_BITS-1:0] ONE_Q     = PROGRESS_BITS'(1) << FRACTION_BITS;

  logic [SAMPLE_BITS-1:0]   level_threshold;
  logic [COUNT_BITS-1:0]    on_delay;
  logic [COUNT_BITS-1:0]    off_delay;
  logic                     is_on;
  logic [COUNT_BITS-1:0]    hold_count;
  logic [SAMPLE_BITS-1:0]   mag;
  logic [COUNT_BITS-1:0]    div_d;
  logic [COUNT_BITS-1:0]    rem;
  logic [FRACTION_BITS-1:0] quot;
  logic                     mode_on;
  logic                     d_zero;
  logic                     n_ge_d;

  logic [SAMPLE_BITS-1:0]   sample_mag;
  logic [COUNT_BITS-1:0]    load_d;
  logic                     counts;
  logic [COUNT_BITS-1:0]    limit;
  logic [COUNT_BITS-1:0]    count_inc;
  logic [COUNT_BITS:0]      rem_dbl;
  logic                     rem_fit;
  logic [PROGRESS_BITS-1:0] quot_up;
  logic [PROGRESS_BITS-1:0] progress_next;

  // magnitude of the incoming sample, most negative value is exact
  assign sample_mag = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
  assign load_d     = is_on ? off_delay : on_delay;

  // hold counter decision from the captured magnitude
  assign counts    = is_on ? (mag < level_threshold) : (mag > level_threshold);
  assign limit     = is_on ? off_delay : on_delay;
  assign count_inc = (hold_count == COUNT_MAX) ? hold_count : hold_count + 1'b1;

  // one restoring divide step
  assign rem_dbl = {rem, 1'b0};
  assign rem_fit = (rem_dbl >= {1'b0, div_d});

  // final progress selection
  assign quot_up = {1'b0, quot} + PROGRESS_BITS'(rem != '0);
  always_comb begin
    if (d_zero) begin
      progress_next = '0;
    end else if (mode_on) begin
      progress_next = n_ge_d ? '0 : (ONE_Q - quot_up);
    end else begin
      progress_next = n_ge_d ? ONE_Q : {1'b0, quot};
    end
  end

  assign status.slot_free = !out_valid || out_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      level_threshold <= '0;
      on_delay        <= '0;
      off_delay       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEVEL_THRESHOLD: level_threshold <= cfg_data[SAMPLE_BITS-1:0];
        REG_ON_DELAY:        on_delay        <= cfg_data[COUNT_BITS-1:0];
        REG_OFF_DELAY:       off_delay       <= cfg_data[COUNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // gate state and hold counter
  always_ff @(posedge clk) begin
    if (rst) begin
      is_on      <= 1'b0;
      hold_count <= '0;
    end else if (cmd.update) begin
      if (counts) begin
        if (count_inc >= limit) begin
          is_on      <= !is_on;
          hold_count <= '0;
        end else begin
          hold_count <= count_inc;
        end
      end else if (hold_count != '0) begin
        hold_count <= hold_count - 1'b1;
      end
    end
  end

  // operand capture and divider
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag     <= sample_mag;
      mode_on <= is_on;
      div_d   <= load_d;
      rem     <= hold_count;
      quot    <= '0;
      d_zero  <= (load_d == '0);
      n_ge_d  <= (hold_count >= load_d);
    end else if (cmd.step) begin
      rem  <= rem_fit ? COUNT_BITS'(rem_dbl - {1'b0, div_d}) : rem_dbl[COUNT_BITS-1:0];
      quot <= {quot[FRACTION_BITS-2:0], rem_fit};
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      gate_on  <= is_on;
      progress <= progress_next;
    end
  end

endmodule

@@ hdl/level_switch_with_delays_top.sv @@
// ----------------------------------------------------------------------------
// level_switch_with_delays_top
// Noise-gate level detector with turn-on and turn-off delays.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one signed sample per transaction; m_axis returns one
//   result per sample holding the gate state after the sample and the
//   progress toward toggling (unsigned Q1.16, taken before the update).
//   cfg writes level_threshold (index 0), on_delay (1) and off_delay (2);
//   other indexes are dropped. cfg_ready is always high; write only while
//   no sample is in flight.
//   A sample transaction loads the divider, the 16-step restoring divider
//   runs, then the result is written into the output register for m_axis.
//   Samples are taken one at a time: a new sample is accepted only once
//   the result of the previous one has been written.
//   A new sample is taken while the previous result still waits on m_axis.
//   When the receiver stalls, the result holds and the block stops after
//   its next division until the output register frees up.
//   Reset clears the gate to off, and the hold counter and config registers to 0.
`timescale 1ns / 1ps

module level_switch_with_delays_top import lswd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  // config write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  // sample stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [S_TDATA_BITS-1:0]   s_axis_tdata,  // [23:0] sample
  // result stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [M_TDATA_BITS-1:0]   m_axis_tdata   // [0] gate_on, [17:1] progress
);

  ctrl_cmd_t                cmd;
  dp_status_t               status;
  logic                     gate_on;
  logic [PROGRESS_BITS-1:0] progress;

  assign cfg_ready = 1'b1;

  // controller
  lswd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  lswd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .gate_on   (gate_on),
    .progress  (progress)
  );

  // result packing, zero padded
  assign m_axis_tdata = M_TDATA_BITS'({progress, gate_on});

endmodule

@@ hdl/lswd_checker.sv @@
// ----------------------------------------------------------------------------
// lswd_checker
// Port-level checks of the level switch, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "level_switch_with_delays_top_assert.svh"

module lswd_checker import lswd_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [M_TDATA_BITS-1:0]   m_axis_tdata
);

  // stalled result holds
  `LSWD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // one sample at a time: busy right after a sample transaction
  `LSWD_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "sample taken while busy")

  // progress never above one
  `LSWD_ASSERT_NOW(a_progress_range, m_axis_tvalid && m_axis_tdata[PROGRESS_BITS], m_axis_tdata[PROGRESS_BITS-1:1] == '0, "progress above one")

  // padding bits stay zero
  `LSWD_ASSERT_NOW(a_pad_zero, m_axis_tvalid, (m_axis_tdata >> (PROGRESS_BITS + 1)) == '0, "nonzero padding in result")

endmodule

bind level_switch_with_delays_top lswd_checker u_lswd_checker (.*);

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the level switch with turn-on and turn-off delays.
// Samples go in over the slave stream and results are read off the master
// stream. A predictor in the bench tracks the gate state and the hold count,
// and each result is compared with the oldest expected transaction. Directed
// cases cover threshold edges, zero and lowered delays and the unused
// register index. Random phases follow with new settings and idle bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import lswd_pkg::*;

  localparam int CLK_HALF_NS    = 5;
  localparam int RESET_CYCLES   = 10;
  localparam int DRAIN_CYCLES   = 24;    // extra wait after the last expected result
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 420;
  localparam int CALM_ITEMS     = 80;    // closing stretch without idling

  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = CFG_INDEX_BITS'(3);
  localparam int unsigned FULL_SCALE = 1 << (SAMPLE_BITS - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [PROGRESS_BITS-1:0] PROGRESS_ONE = PROGRESS_BITS'(1 << FRACTION_BITS);

  typedef struct packed {
    logic                     gate_on;
    logic [PROGRESS_BITS-1:0] progress;
  } gate_result_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // dut ports
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [S_TDATA_BITS-1:0]   s_axis_tdata = '0;   // [23:0] sample
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b1;
  logic [M_TDATA_BITS-1:0]   m_axis_tdata;        // [0] gate_on, [17:1] progress

  // predictor state and register copies
  logic [SAMPLE_BITS-1:0] level_thr_q = '0;
  logic [COUNT_BITS-1:0]  on_delay_q = '0;
  logic [COUNT_BITS-1:0]  off_delay_q = '0;
  logic [COUNT_BITS-1:0]  hold_q = '0;
  logic                   gate_q = 1'b0;

  gate_result_t pending_results[$];

  int  error_count = 0;
  int  samples_sent = 0;
  int  results_seen = 0;
  int  gate_toggles = 0;
  int  reg_writes = 0;
  int  random_sent = 0;
  int  stall_left = 0;
  int  stuck_cycles = 0;
  bit  idle_en = 1'b0;

  level_switch_with_delays_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock generation
  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  // mismatch reporting
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // gate predictor: progress before the update, state after it
  function automatic gate_result_t predict_gate(input logic [SAMPLE_BITS-1:0] smp);
    gate_result_t           r;
    logic [SAMPLE_BITS-1:0] mag;
    logic [COUNT_BITS-1:0]  limit;
    logic [63:0]            scaled;
    logic                   counts;
    mag    = smp[SAMPLE_BITS-1] ? (~smp + 1'b1) : smp;
    scaled = 64'(hold_q) << FRACTION_BITS;
    if (gate_q) begin
      limit  = off_delay_q;
      counts = mag < level_thr_q;
      if (limit == 0 || hold_q >= limit) r.progress = '0;
      else r.progress = PROGRESS_ONE - PROGRESS_BITS'((scaled + 64'(limit) - 1) / 64'(limit));
    end else begin
      limit  = on_delay_q;
      counts = mag > level_thr_q;
      if (limit == 0) r.progress = '0;
      else if (hold_q >= limit) r.progress = PROGRESS_ONE;
      else r.progress = PROGRESS_BITS'(scaled / 64'(limit));
    end
    if (counts) begin
      if (hold_q != COUNT_MAX) hold_q = hold_q + 1'b1;
      if (hold_q >= limit) begin
        gate_q = ~gate_q;
        hold_q = '0;
        gate_toggles++;
      end
    end else if (hold_q != 0) begin
      hold_q = hold_q - 1'b1;
    end
    r.gate_on = gate_q;
    return r;
  endfunction

  // signed sample of a given magnitude
  function automatic logic [SAMPLE_BITS-1:0] make_sample(input int unsigned mag,
                                                         input bit neg);
    bit use_neg;
    use_neg = neg;
    if (mag == FULL_SCALE) use_neg = 1'b1;
    if (mag == 0) use_neg = 1'b0;
    return SAMPLE_BITS'(use_neg ? (0 - mag) : mag);
  endfunction

  // sample strictly above (loud) or strictly below the threshold, random when no such magnitude exists
  function automatic logic [SAMPLE_BITS-1:0] level_sample(input bit loud);
    int unsigned thr;
    int unsigned lo;
    int unsigned hi;
    thr = level_thr_q;
    if (loud) begin
      if (thr >= FULL_SCALE) return SAMPLE_BITS'($urandom);
      lo = thr + 1;
      hi = FULL_SCALE;
    end else begin
      if (thr == 0) return SAMPLE_BITS'($urandom);
      lo = 0;
      hi = (thr - 1 > FULL_SCALE) ? FULL_SCALE : thr - 1;
    end
    return make_sample($urandom_range(hi, lo), $urandom_range(0, 1));
  endfunction

  // any bit pattern, sometimes sitting exactly on the threshold
  function automatic logic [SAMPLE_BITS-1:0] noise_sample();
    logic [SAMPLE_BITS-1:0] smp;
    smp = SAMPLE_BITS'($urandom);
    if ($urandom_range(0, 2) == 0 && level_thr_q <= FULL_SCALE)
      smp = make_sample(level_thr_q, $urandom_range(0, 1));
    return smp;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_threshold();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return SAMPLE_BITS'(FULL_SCALE);
      2: return '1;
      3: return SAMPLE_BITS'($urandom);
      default: return SAMPLE_BITS'($urandom_range(0, FULL_SCALE));
    endcase
  endfunction

  function automatic logic [COUNT_BITS-1:0] pick_delay();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return COUNT_MAX;
      2: return COUNT_BITS'($urandom);
      default: return COUNT_BITS'($urandom_range(1, 12));
    endcase
  endfunction

  // one register write transaction, valid left high for a following write
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LEVEL_THRESHOLD: level_thr_q = val[SAMPLE_BITS-1:0];
      REG_ON_DELAY:        on_delay_q  = val[COUNT_BITS-1:0];
      REG_OFF_DELAY:       off_delay_q = val[COUNT_BITS-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic configure_gate(input logic [SAMPLE_BITS-1:0] thr,
                                input logic [COUNT_BITS-1:0] on_dly,
                                input logic [COUNT_BITS-1:0] off_dly);
    write_reg(REG_LEVEL_THRESHOLD, CFG_DATA_BITS'(thr));
    write_reg(REG_ON_DELAY, CFG_DATA_BITS'(on_dly));
    write_reg(REG_OFF_DELAY, CFG_DATA_BITS'(off_dly));
    cfg_valid <= 1'b0;
  endtask

  // one sample transaction, with an optional idle burst before it
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_BITS'(smp);
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(predict_gate(smp));
    samples_sent++;
  endtask

  // stop sending and let every expected result drain
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // registers at reset values: zero threshold and zero delays
  task automatic test_reset_defaults();
    send_sample('0);
    send_sample(SAMPLE_BITS'(1));
    wait_idle();
  endtask

  // zero delays toggle on the first counting sample
  task automatic test_zero_delay();
    configure_gate(SAMPLE_BITS'(100), '0, '0);
    send_sample(SAMPLE_BITS'(5));
    send_sample(SAMPLE_BITS'(-200));
    send_sample(SAMPLE_BITS'(100));
    wait_idle();
  endtask

  // largest positive, most negative, zero and minus one around the threshold
  task automatic test_sample_extremes();
    configure_gate(SAMPLE_BITS'(FULL_SCALE - 1), COUNT_BITS'(2), COUNT_BITS'(2));
    send_sample(SAMPLE_BITS'(FULL_SCALE - 1));
    send_sample('0);
    send_sample('1);
    send_sample(SAMPLE_BITS'(FULL_SCALE));
    send_sample(SAMPLE_BITS'(FULL_SCALE - 1));
    send_sample(SAMPLE_BITS'(FULL_SCALE));
    send_sample(SAMPLE_BITS'(FULL_SCALE));
    wait_idle();
  endtask

  // delay lowered below the running count while the gate is off
  task automatic test_lowered_delay();
    configure_gate(SAMPLE_BITS'(1000), COUNT_BITS'(8), COUNT_BITS'(8));
    repeat (3) send_sample(SAMPLE_BITS'(-12));
    wait_idle();
    write_reg(REG_OFF_DELAY, CFG_DATA_BITS'(2));
    cfg_valid <= 1'b0;
    send_sample(SAMPLE_BITS'(5000));
    send_sample(SAMPLE_BITS'(999));
    repeat (3) send_sample(SAMPLE_BITS'(-1001));
    wait_idle();
    write_reg(REG_ON_DELAY, CFG_DATA_BITS'(2));
    cfg_valid <= 1'b0;
    send_sample(SAMPLE_BITS'(1000));
    send_sample(SAMPLE_BITS'(1001));
    wait_idle();
  endtask

  // a write to the unused index must leave every register alone
  task automatic test_unused_register();
    configure_gate(SAMPLE_BITS'(50), COUNT_BITS'(3), COUNT_BITS'(3));
    write_reg(REG_UNUSED, '1);
    cfg_valid <= 1'b0;
    send_sample('0);
    send_sample(SAMPLE_BITS'(10));
    send_sample(SAMPLE_BITS'(-49));
    wait_idle();
  endtask

  // random settings, then runs that push toward toggling mixed with noise
  task automatic test_random_gating();
    int                        phase_len;
    int                        k;
    int                        run_len;
    int unsigned               run_cap;
    bit                        loud;
    logic [CFG_INDEX_BITS-1:0] reg_pick;
    logic [COUNT_BITS-1:0]     limit;
    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      idle_en = (random_sent < RANDOM_ITEMS - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) begin
        reg_pick = CFG_INDEX_BITS'($urandom);
        if (reg_pick == REG_LEVEL_THRESHOLD)
          write_reg(reg_pick, CFG_DATA_BITS'(pick_threshold()));
        else
          write_reg(reg_pick, CFG_DATA_BITS'(pick_delay()));
        cfg_valid <= 1'b0;
      end else begin
        configure_gate(pick_threshold(), pick_delay(), pick_delay());
      end
      phase_len = $urandom_range(15, 40);
      k = 0;
      while (k < phase_len) begin
        if ($urandom_range(0, 4) == 0) begin
          send_sample(noise_sample());
          k++;
        end else begin
          loud = ~gate_q;
          if ($urandom_range(0, 3) == 0) loud = ~loud;
          limit   = gate_q ? off_delay_q : on_delay_q;
          run_cap = (limit < 20) ? limit : 20;
          run_len = $urandom_range(1, run_cap + 2);
          repeat (run_len) begin
            send_sample(level_sample(loud));
            k++;
          end
        end
      end
      random_sent += k;
    end
    idle_en = 1'b0;
  endtask

  // receiver side: ready with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b1;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 10);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker against the oldest expected transaction
  always @(posedge clk) begin : check_results
    gate_result_t want;
    logic         got_gate;
    logic [PROGRESS_BITS-1:0] got_progress;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_gate     = m_axis_tdata[0];
      got_progress = m_axis_tdata[PROGRESS_BITS:1];
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no sample pending", results_seen));
      end else begin
        want = pending_results.pop_front();
        if (got_gate !== want.gate_on)
          report_mismatch($sformatf("result %0d gate_on got %0b want %0b",
                                    results_seen, got_gate, want.gate_on));
        if (got_progress !== want.progress)
          report_mismatch($sformatf("result %0d progress got %0d want %0d",
                                    results_seen, got_progress, want.progress));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", stuck_cycles);
      $display("** level_switch_with_delays_top: FAILED **");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // test sequence
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_zero_delay();
    test_sample_extremes();
    test_lowered_delay();
    test_unused_register();
    test_random_gating();
    wait_idle();
    $display("run covered %0d samples, %0d results, %0d gate toggles, %0d register writes",
             samples_sent, results_seen, gate_toggles, reg_writes);
    $display("mismatches found: %0d", error_count);
    if (error_count == 0) begin
      $display("** level_switch_with_delays_top: PASSED **");
    end else begin
      $display("** level_switch_with_delays_top: FAILED **");
    end
    $finish;
  end

endmodule
